// ===== design/dpb_pkg.sv =====
// ----------------------------------------------------------------------------
// Depth pixel back-projection package
// Shared types and constants for the back-projection block.
// ----------------------------------------------------------------------------
package dpb_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int NUM_W   = 45;
  localparam int DIV_W   = 49;
  localparam int CNT_W   = 25;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] COUNT_MAX = 25'd16777216;
  localparam logic signed [NUM_W-1:0] ONE_Q28 = 45'sd268435456;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FX     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FY     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CX     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CY     = 3'd5;

  typedef struct packed {
    logic [12:0]        image_width;
    logic [12:0]        image_height;
    logic signed [31:0] inv_focal_x;
    logic signed [31:0] inv_focal_y;
    logic signed [31:0] inv_center_x;
    logic signed [31:0] inv_center_y;
  } cfg_t;

  typedef struct packed {
    logic signed [NUM_W-1:0] nx;
    logic signed [NUM_W-1:0] ny;
    logic signed [23:0]      inv_depth;
    logic signed [23:0]      depth_variance;
    logic [15:0]             intensity;
    logic signed [15:0]      grad_x;
    logic signed [15:0]      grad_y;
    logic [23:0]             pixel_index;
    logic                    keep;
    logic                    last;
  } entry_t;

endpackage

// ===== design/dpb_if.sv =====
// ----------------------------------------------------------------------------
// Depth pixel back-projection channels
// Valid/ready channels for incoming pixels and outgoing points.
// ----------------------------------------------------------------------------
interface dpb_pix_if;
  logic               valid;
  logic               ready;
  logic [11:0]        col;
  logic [11:0]        row;
  logic signed [23:0] inv_depth;
  logic signed [23:0] depth_variance;
  logic [15:0]        intensity;
  logic signed [15:0] grad_x;
  logic signed [15:0] grad_y;
  logic               last_pixel;

  modport source (output valid, col, row, inv_depth, depth_variance, intensity,
                  grad_x, grad_y, last_pixel, input ready);
  modport sink (input valid, col, row, inv_depth, depth_variance, intensity,
                grad_x, grad_y, last_pixel, output ready);
endinterface

interface dpb_pt_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic signed [31:0] point_z;
  logic signed [15:0] out_grad_x;
  logic signed [15:0] out_grad_y;
  logic [15:0]        out_intensity;
  logic signed [23:0] out_variance;
  logic [23:0]        pixel_index;
  logic [24:0]        point_count;
  logic               is_point;
  logic               is_last;

  modport source (output valid, point_x, point_y, point_z, out_grad_x, out_grad_y,
                  out_intensity, out_variance, pixel_index, point_count, is_point,
                  is_last, input ready);
  modport sink (input valid, point_x, point_y, point_z, out_grad_x, out_grad_y,
                out_intensity, out_variance, pixel_index, point_count, is_point,
                is_last, output ready);
endinterface

// ===== design/depth_pixel_backprojection.sv =====
// ----------------------------------------------------------------------------
// Depth pixel back-projection
// Turns an inverse-depth pixel stream into Q16.16 3D points.
// A kept pixel holds the back end through a dequeue, three 49-step divisions with
// a load and a finish state each, and the result handoff.
// A dropped last pixel is only dequeued and handed off; other drops cost nothing.
// Synchronous reset restores default registers and clears the point counter.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection #(
  parameter int MAX_WIDTH  = dpb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dpb_pkg::DEF_MAX_HEIGHT
) (
  input  logic clk,
  input  logic rst,
  dpb_pix_if.sink  pix,
  dpb_pt_if.source pts,
  input  logic cfg_we,
  input  logic [dpb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0] cfg_data
);
  dpb_pkg::cfg_t   cfg;
  dpb_pkg::entry_t fentry;
  dpb_pkg::entry_t head;
  logic wanted;
  logic push;
  logic pop;
  logic full;
  logic empty;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width <= 13'd640;
      cfg.image_height <= 13'd480;
      cfg.inv_focal_x <= '0;
      cfg.inv_focal_y <= '0;
      cfg.inv_center_x <= '0;
      cfg.inv_center_y <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        dpb_pkg::REG_WIDTH:  cfg.image_width <= cfg_data[12:0];
        dpb_pkg::REG_HEIGHT: cfg.image_height <= cfg_data[12:0];
        dpb_pkg::REG_FX:     cfg.inv_focal_x <= cfg_data;
        dpb_pkg::REG_FY:     cfg.inv_focal_y <= cfg_data;
        dpb_pkg::REG_CX:     cfg.inv_center_x <= cfg_data;
        dpb_pkg::REG_CY:     cfg.inv_center_y <= cfg_data;
        default: ;
      endcase
    end
  end

  dpb_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .cfg(cfg), .col(pix.col), .row(pix.row), .inv_depth(pix.inv_depth),
    .depth_variance(pix.depth_variance), .intensity(pix.intensity),
    .grad_x(pix.grad_x), .grad_y(pix.grad_y), .last_pixel(pix.last_pixel),
    .entry(fentry), .wanted(wanted)
  );

  assign pix.ready = !full && !rst;
  assign push = pix.valid && pix.ready && wanted;

  dpb_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .wdata(fentry), .pop(pop),
    .rdata(head), .full(full), .empty(empty), .count(count)
  );

  dpb_back u_back (
    .clk(clk), .rst(rst), .empty(empty), .head(head), .pop(pop), .pts(pts)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= 2'd2)
    else $error("queue count exceeds depth");
  a_pop_free: assert property (@(posedge clk) disable iff (rst) pop |-> !pts.valid)
    else $error("pop while result register occupied");
  a_nopoint_last: assert property (@(posedge clk) disable iff (rst)
      (pts.valid && !pts.is_point) |-> pts.is_last)
    else $error("empty result that is not last");
  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full queue");
endmodule

// ===== design/dpb_front.sv =====
// ----------------------------------------------------------------------------
// Pixel classifier
// Checks bounds and validity, forms numerators and the linear pixel index.
// ----------------------------------------------------------------------------
module dpb_front #(
  parameter int MAX_WIDTH  = dpb_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = dpb_pkg::DEF_MAX_HEIGHT
) (
  input  dpb_pkg::cfg_t   cfg,
  input  logic [11:0]     col,
  input  logic [11:0]     row,
  input  logic signed [23:0] inv_depth,
  input  logic signed [23:0] depth_variance,
  input  logic [15:0]     intensity,
  input  logic signed [15:0] grad_x,
  input  logic signed [15:0] grad_y,
  input  logic            last_pixel,
  output dpb_pkg::entry_t entry,
  output logic            wanted
);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);

  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic          keep;

  always_comb begin
    w = (int'(cfg.image_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg.image_width);
    h = (int'(cfg.image_height) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg.image_height);
    keep = (col != 12'd0) && (int'(col) + 1 < int'(w)) &&
           (row != 12'd0) && (int'(row) + 1 < int'(h)) &&
           (depth_variance > 24'sd0) && (inv_depth != 24'sd0);
    entry.nx = cfg.inv_focal_x * $signed({1'b0, col}) + cfg.inv_center_x;
    entry.ny = cfg.inv_focal_y * $signed({1'b0, row}) + cfg.inv_center_y;
    entry.inv_depth = inv_depth;
    entry.depth_variance = depth_variance;
    entry.intensity = intensity;
    entry.grad_x = grad_x;
    entry.grad_y = grad_y;
    entry.pixel_index = 24'(32'(col) + 32'(row) * 32'(w));
    entry.keep = keep;
    entry.last = last_pixel;
    wanted = keep || last_pixel;
  end
endmodule

// ===== design/dpb_queue.sv =====
// ----------------------------------------------------------------------------
// Classified pixel queue
// Two-entry queue between the classifier and the divider back end.
// ----------------------------------------------------------------------------
module dpb_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dpb_pkg::entry_t wdata,
  input  logic            pop,
  output dpb_pkg::entry_t rdata,
  output logic            full,
  output logic            empty,
  output logic [1:0]      count
);
  dpb_pkg::entry_t mem [2];
  logic wptr;
  logic rptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
    if (push) begin
      mem[wptr] <= wdata;
    end
  end

  assign rdata = mem[rptr];
  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
endmodule

// ===== design/dpb_back.sv =====
// ----------------------------------------------------------------------------
// Divider back end
// Runs three rounded, saturated divisions per point and counts points.
// ----------------------------------------------------------------------------
module dpb_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            empty,
  input  dpb_pkg::entry_t head,
  output logic            pop,
  dpb_pt_if.source        pts
);
  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_DIV, S_FINISH} state_t;

  state_t state;
  dpb_pkg::entry_t cur;
  logic [1:0]  sel;
  logic [5:0]  step;
  logic        neg;
  logic [23:0] dm;
  logic [23:0] rem;
  logic [dpb_pkg::DIV_W-1:0] num;
  logic [dpb_pkg::DIV_W-1:0] quo;
  logic signed [31:0] res [3];
  logic [dpb_pkg::CNT_W-1:0] points_emitted;

  logic signed [dpb_pkg::NUM_W-1:0] numer;
  logic [dpb_pkg::NUM_W-1:0] nm_next;
  logic [23:0] dm_next;
  logic [24:0] rem_sh;
  logic        take;
  logic [31:0] sat;
  logic [dpb_pkg::CNT_W-1:0] cnt_inc;

  always_comb begin
    case (sel)
      2'd0:    numer = cur.nx;
      2'd1:    numer = cur.ny;
      default: numer = dpb_pkg::ONE_Q28;
    endcase
    nm_next = numer[dpb_pkg::NUM_W-1] ? dpb_pkg::NUM_W'(-numer) : dpb_pkg::NUM_W'(numer);
    dm_next = cur.inv_depth[23] ? 24'(-cur.inv_depth) : 24'(cur.inv_depth);
    rem_sh = {rem, num[dpb_pkg::DIV_W-1]};
    take = rem_sh >= {1'b0, dm};
    if (!neg) begin
      sat = (quo > dpb_pkg::DIV_W'(32'h7FFFFFFF)) ? 32'h7FFFFFFF : quo[31:0];
    end else begin
      sat = (quo > dpb_pkg::DIV_W'(33'h080000000)) ? 32'h80000000 : 32'(-quo);
    end
    cnt_inc = (points_emitted < dpb_pkg::COUNT_MAX) ? points_emitted + 25'd1
                                                   : points_emitted;
  end

  assign pop = (state == S_IDLE) && !empty && !pts.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pts.valid <= 1'b0;
      points_emitted <= '0;
    end else begin
      if (pts.valid && pts.ready) begin
        pts.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop) begin
            cur <= head;
            sel <= 2'd0;
            if (head.keep) begin
              state <= S_LOAD;
            end else begin
              pts.valid <= 1'b1;
              pts.point_x <= '0;
              pts.point_y <= '0;
              pts.point_z <= '0;
              pts.out_grad_x <= '0;
              pts.out_grad_y <= '0;
              pts.out_intensity <= '0;
              pts.out_variance <= '0;
              pts.pixel_index <= '0;
              pts.point_count <= points_emitted;
              pts.is_point <= 1'b0;
              pts.is_last <= 1'b1;
              points_emitted <= '0;
            end
          end
        end
        S_LOAD: begin
          neg <= numer[dpb_pkg::NUM_W-1] ^ cur.inv_depth[23];
          dm <= dm_next;
          num <= dpb_pkg::DIV_W'({nm_next[43:0], 4'b0000}) + dpb_pkg::DIV_W'(dm_next >> 1);
          rem <= '0;
          quo <= '0;
          step <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem <= take ? 24'(rem_sh - {1'b0, dm}) : rem_sh[23:0];
          quo <= {quo[dpb_pkg::DIV_W-2:0], take};
          num <= {num[dpb_pkg::DIV_W-2:0], 1'b0};
          step <= step + 6'd1;
          if (step == 6'(dpb_pkg::DIV_W - 1)) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          res[sel] <= sat;
          if (sel != 2'd2) begin
            sel <= sel + 2'd1;
            state <= S_LOAD;
          end else begin
            state <= S_IDLE;
            pts.valid <= 1'b1;
            pts.point_x <= res[0];
            pts.point_y <= res[1];
            pts.point_z <= sat;
            pts.out_grad_x <= cur.grad_x;
            pts.out_grad_y <= cur.grad_y;
            pts.out_intensity <= cur.intensity;
            pts.out_variance <= cur.depth_variance;
            pts.pixel_index <= cur.pixel_index;
            pts.is_point <= 1'b1;
            pts.is_last <= cur.last;
            if (cur.last) begin
              pts.point_count <= cnt_inc;
              points_emitted <= '0;
            end else begin
              pts.point_count <= points_emitted;
              points_emitted <= cnt_inc;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
